@@ rtl/sorted_table_binary_search_core_defines.svh @@
// Assertion helpers for the RTL, included by stbs_ctrl.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH

// Checked only while out of reset.
`define SRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked on every edge, reset included.
`define SRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/stbs_pkg.sv @@
package stbs_pkg;

  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned ADDR_W  = 3;
  // wide enough to hold any DEPTH in range
  localparam int unsigned EXT_W   = 17;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } stbs_state_t;

  typedef struct packed {
    logic             strobe;
    logic             found;
    logic [POS_W-1:0] position;
  } stbs_result_t;

endpackage

@@ rtl/stbs_regs.sv @@
module stbs_regs
  import stbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [COUNT_W-1:0]   entry_count
);

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);

  always_comb begin
    count_nxt = count_r;
    if (wr_hit) begin
      count_nxt = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign prdata      = (paddr[2] == REG_ENTRY_COUNT) ? 32'(count_r) : 32'd0;
  assign entry_count = count_r;

endmodule

@@ rtl/stbs_mem.sv @@
module stbs_mem
  import stbs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/stbs_ctrl.sv @@
`include "sorted_table_binary_search_core_defines.svh"

module stbs_ctrl
  import stbs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  func,
  input  logic [SLOT_W-1:0]     slot,
  input  logic [VALUE_W-1:0]    value,
  input  logic [COUNT_W-1:0]    entry_count,
  output logic                  busy,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata,
  output stbs_result_t          result
);

  stbs_state_t           state_r, state_nxt;
  logic [NW-1:0]         low_r, low_nxt;
  logic [NW-1:0]         hx_r, hx_nxt;     // exclusive upper bound
  logic [AW-1:0]         mid_r, mid_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  stbs_result_t          res_r, res_nxt;

  logic [63:0]           val64;
  logic [EXT_W-1:0]      slot_ext;
  logic [EXT_W-1:0]      cnt_ext;
  logic [EXT_W-1:0]      n_ext;
  logic [NW-1:0]         n;
  logic [NW-1:0]         mid_w;
  logic [NW-1:0]         lo_c, hx_c;
  logic [EXT_W-1:0]      mid_ext;
  logic                  accept;
  logic                  eq, gt;

  assign accept   = start && (state_r == ST_IDLE);
  assign val64    = 64'(value);
  assign slot_ext = EXT_W'(slot);
  assign cnt_ext  = EXT_W'(entry_count);
  assign n_ext    = (cnt_ext > EXT_W'(DEPTH)) ? EXT_W'(DEPTH) : cnt_ext;
  assign n        = n_ext[NW-1:0];
  assign mid_w    = NW'(mid_r);
  assign mid_ext  = EXT_W'(mid_r);
  assign eq       = (mem_rdata == key_r);
  assign gt       = $signed(key_r) > $signed(mem_rdata);

  // loads write straight through; slots past the table are dropped
  assign mem_we    = accept && (func == FUNC_LOAD) && (slot_ext < EXT_W'(DEPTH));
  assign mem_waddr = slot_ext[AW-1:0];
  assign mem_wdata = val64[DATA_WIDTH-1:0];

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    hx_nxt    = hx_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    res_nxt   = '0;
    mem_re    = 1'b0;
    lo_c      = low_r;
    hx_c      = hx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (func == FUNC_SEARCH)) begin
          key_nxt = val64[DATA_WIDTH-1:0];
          if (n == '0) begin
            res_nxt.strobe = 1'b1;
          end else begin
            low_nxt   = '0;
            hx_nxt    = n;
            mid_nxt   = AW'((n - NW'(1)) >> 1);
            mem_re    = 1'b1;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (eq) begin
          res_nxt.strobe   = 1'b1;
          res_nxt.found    = 1'b1;
          res_nxt.position = mid_ext[POS_W-1:0];
          state_nxt        = ST_IDLE;
        end else begin
          lo_c    = gt ? (mid_w + NW'(1)) : low_r;
          hx_c    = gt ? hx_r : mid_w;
          low_nxt = lo_c;
          hx_nxt  = hx_c;
          if (lo_c < hx_c) begin
            mid_nxt = AW'(lo_c + ((hx_c - lo_c - NW'(1)) >> 1));
            mem_re  = 1'b1;
          end else begin
            res_nxt.strobe = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign mem_raddr = mid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r <= low_nxt;
    hx_r  <= hx_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
  end

  assign busy   = (state_r != ST_IDLE);
  assign result = res_r;

  `SRT_ASSERT(a_mid_in_window, clk, rst_n, (state_r == ST_PROBE) |-> ((low_r <= mid_w) && (mid_w < hx_r)), "probe outside window")
  `SRT_ASSERT(a_window_shrinks, clk, rst_n, ((state_r == ST_PROBE) && $past(state_r == ST_PROBE) && $past(rst_n)) |-> ((hx_r - low_r) < $past(hx_r - low_r)), "window did not shrink")
  `SRT_ASSERT(a_miss_pos_zero, clk, rst_n, (res_r.strobe && !res_r.found) |-> (res_r.position == '0), "miss with nonzero position")
  `SRT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> ((state_r == ST_IDLE) && !res_r.strobe), "reset left block active")

endmodule

@@ rtl/sorted_table_binary_search_core.sv @@
// Sorted-table binary search core.
// Input channel: an item (in_func, in_slot, in_value) is taken at a clock edge with
//   start high and busy low. in_func load writes in_value into table entry in_slot
//   (slots at or beyond DEPTH are dropped) and gives no result.
// A search looks for in_value over entries 0 .. entry_count-1 (count clamped to DEPTH),
//   probing one table entry per cycle through the synchronous memory read port.
//   Each search makes k probes, where k is the number of probes needed,
//   at most ceil(log2(n+1)) (11 at 1024 entries); out_strobe follows the last probe, and busy is high while probing.
//   An empty table answers in the cycle after accept. A new transaction may be accepted
//   in the cycle the result is shown.
// Result channel: out_strobe is high for one cycle with out_found and out_position
//   (0 on a miss). The receiver cannot stall; results must be taken when shown.
// Config: APB-style port; entry_count at byte address 0. Write only while idle.
// Reset (rst_n low, synchronous) returns to idle and clears entry_count. Table
//   contents are not cleared; entries must be loaded before a search reads them.
module sorted_table_binary_search_core
  import stbs_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [VALUE_W-1:0]  in_value,
  // result channel
  output logic                out_strobe,
  output logic                out_found,
  output logic [POS_W-1:0]    out_position,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [COUNT_W-1:0]    entry_count;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  stbs_result_t          result;

  stbs_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .entry_count (entry_count)
  );

  // table storage: one write port for loads, one read port for probes
  stbs_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // search sequencer: issues the next probe address as soon as read data compares
  stbs_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .func        (in_func),
    .slot        (in_slot),
    .value       (in_value),
    .entry_count (entry_count),
    .busy        (busy),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .result      (result)
  );

  assign out_strobe   = result.strobe;
  assign out_found    = result.found;
  assign out_position = result.position;

endmodule
